FILE: sv/rmcs_pkg.sv
// Shared widths and limits for the running mean / contraharmonic mean block.
// Used by the top level, the bit-serial divider and the port checker.
package rmcs_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int COUNT_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int MEAN_BITS    = 24;
    localparam int CH_BITS      = 54;

    localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS      = 2 * SAMPLE_BITS;
    localparam int SQ_SUM_BITS  = 2 * (SAMPLE_BITS - 1) + COUNT_BITS + 1;

    // divider sizing: dividend is the widest numerator shifted by the fraction bits
    localparam int DIV_NUM_W    = SQ_SUM_BITS + FRAC_BITS;
    localparam int DIV_DEN_W    = SUM_BITS + 1;
    localparam int DIV_STEP_W   = $clog2(DIV_NUM_W + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [DIV_NUM_W-1:0] MEAN_POS_LIM =
        {{(DIV_NUM_W - MEAN_BITS + 1){1'b0}}, {(MEAN_BITS - 1){1'b1}}};
    localparam logic [DIV_NUM_W-1:0] MEAN_NEG_LIM =
        {{(DIV_NUM_W - MEAN_BITS){1'b0}}, 1'b1, {(MEAN_BITS - 1){1'b0}}};
    localparam logic [DIV_NUM_W-1:0] CH_LIM =
        {{(DIV_NUM_W - CH_BITS){1'b0}}, {CH_BITS{1'b1}}};

    localparam logic [MEAN_BITS-1:0] MEAN_MAX_OUT = {1'b0, {(MEAN_BITS - 1){1'b1}}};
    localparam logic [MEAN_BITS-1:0] MEAN_MIN_OUT = {1'b1, {(MEAN_BITS - 1){1'b0}}};

endpackage

FILE: sv/running_mean_contraharmonic_stats.sv
// Top level: running count, sum, sum of squares and peak, with mean and
// contraharmonic mean computed by two bit-serial dividers (rmcs_div, rmcs_pkg).
//
//   channel  | valid       | ready        | word
//   ---------+-------------+--------------+------------------------------------------
//   input    | i_in_valid  | o_in_ready   | i_action, i_sample
//   result   | o_out_valid | i_out_ready  | o_mean_q8, o_contraharmonic_q8, o_count,
//            |             |              | o_largest, o_overflow
//   config   | i_cfg_valid | o_cfg_ready  | i_cfg_include_max
//
// One word goes through these steps from acceptance to a valid result: the
// accumulators are updated, numerators and denominators are formed, then
// the two dividers running side by side produce DIV_NUM_W (55) quotient bits,
// the control sees both dividers idle, and the result is saturated into the
// output register. No new word is accepted while one is in progress.
// Reset (synchronous, active low) clears all statistics and sets include_max.
// A result waiting on a stalled output holds the block in the final step;
// a new input word is taken once the previous result is in the output register.
module running_mean_contraharmonic_stats import rmcs_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [MEAN_BITS-1:0]   o_mean_q8,
    output logic [CH_BITS-1:0]            o_contraharmonic_q8,
    output logic [COUNT_BITS-1:0]         o_count,
    output logic signed [SAMPLE_BITS-1:0] o_largest,
    output logic                          o_overflow,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_include_max
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // captured word
    logic                          r_action;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [SQ_BITS-1:0]            r_sq;

    // accumulated statistics
    logic [COUNT_BITS-1:0]         r_count;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic [SQ_SUM_BITS-1:0]        r_sq_sum;
    logic signed [SAMPLE_BITS-1:0] r_peak;
    logic [SQ_BITS-1:0]            r_peak_sq;
    logic                          r_ovf;
    logic                          r_incl;

    // flags for the division in flight
    logic r_neg;
    logic r_mean_zero;
    logic r_contra_zero;

    logic                          r_out_valid;
    logic signed [MEAN_BITS-1:0]   r_out_mean;
    logic [CH_BITS-1:0]            r_out_ch;
    logic [COUNT_BITS-1:0]         r_out_count;
    logic signed [SAMPLE_BITS-1:0] r_out_peak;
    logic                          r_out_ovf;

    logic                          w_in_fire;
    logic [SAMPLE_BITS-1:0]        w_in_mag;
    logic [SQ_BITS-1:0]            w_in_sq;
    logic                          w_new_peak;

    logic signed [SUM_BITS:0]      w_num_m;
    logic signed [COUNT_BITS:0]    w_den_m;
    logic [SUM_BITS:0]             w_mag;
    logic                          w_neg;
    logic                          w_mean_zero;
    logic [SQ_SUM_BITS-1:0]        w_p2;
    logic [SQ_SUM_BITS-1:0]        w_num_c;
    logic                          w_contra_zero;

    logic                          w_start;
    logic [DIV_NUM_W-1:0]          w_dvd_m;
    logic [DIV_DEN_W-1:0]          w_dvs_m;
    logic [DIV_NUM_W-1:0]          w_dvd_c;
    logic [DIV_DEN_W-1:0]          w_dvs_c;
    logic                          w_busy_m;
    logic                          w_busy_c;
    logic [DIV_NUM_W-1:0]          w_q_m;
    logic [DIV_NUM_W-1:0]          w_q_c;

    logic signed [MEAN_BITS-1:0]   w_mean;
    logic [CH_BITS-1:0]            w_ch;
    logic                          w_load_out;

    assign w_in_fire = i_in_valid & o_in_ready;

    // square the incoming sample on the way in; the peak square reuses it
    assign w_in_mag = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
    assign w_in_sq  = w_in_mag * w_in_mag;

    assign w_new_peak = (r_count == '0) || (r_sample > r_peak);

    // numerator and denominator of the mean; the sum minus peak also serves
    // as the contraharmonic denominator
    assign w_num_m = {r_sum[SUM_BITS-1], r_sum}
                   - (r_incl ? '0 : {{(SUM_BITS + 1 - SAMPLE_BITS){r_peak[SAMPLE_BITS-1]}},
                                     r_peak});
    assign w_den_m = {1'b0, r_count} - (r_incl ? '0 : (COUNT_BITS + 1)'(1));
    assign w_neg   = w_num_m[SUM_BITS];
    assign w_mag   = w_neg ? (~w_num_m + 1'b1) : w_num_m;
    assign w_mean_zero = w_den_m[COUNT_BITS] || (w_den_m == '0);

    assign w_p2    = r_incl ? '0 : {{(SQ_SUM_BITS - SQ_BITS){1'b0}}, r_peak_sq};
    assign w_num_c = r_sq_sum - w_p2;
    assign w_contra_zero = (w_p2 >= r_sq_sum) || w_neg || (w_num_m == '0);

    assign w_start = (r_state == S_PREP);
    assign w_dvd_m = {{(DIV_NUM_W - SUM_BITS - 1 - FRAC_BITS){1'b0}}, w_mag,
                      {FRAC_BITS{1'b0}}};
    assign w_dvs_m = {{(DIV_DEN_W - COUNT_BITS){1'b0}}, w_den_m[COUNT_BITS-1:0]};
    assign w_dvd_c = {w_num_c, {FRAC_BITS{1'b0}}};
    assign w_dvs_c = w_num_m[DIV_DEN_W-1:0];

    rmcs_div u_div_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd_m),
        .i_divisor  (w_dvs_m),
        .o_busy     (w_busy_m),
        .o_quotient (w_q_m)
    );

    rmcs_div u_div_ch (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd_c),
        .i_divisor  (w_dvs_c),
        .o_busy     (w_busy_c),
        .o_quotient (w_q_c)
    );

    // saturate quotients into the output ranges, apply sign, force zeros
    always_comb begin
        if (r_mean_zero) begin
            w_mean = '0;
        end else if (!r_neg) begin
            w_mean = (w_q_m > MEAN_POS_LIM) ? MEAN_MAX_OUT : w_q_m[MEAN_BITS-1:0];
        end else begin
            w_mean = (w_q_m > MEAN_NEG_LIM) ? MEAN_MIN_OUT
                                            : (~w_q_m[MEAN_BITS-1:0] + 1'b1);
        end
        if (r_contra_zero) begin
            w_ch = '0;
        end else begin
            w_ch = (w_q_c > CH_LIM) ? CH_LIM[CH_BITS-1:0] : w_q_c[CH_BITS-1:0];
        end
    end

    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) n_state = S_UPD;
            end
            S_UPD:  n_state = S_PREP;
            S_PREP: n_state = S_DIV;
            S_DIV: begin
                if (!w_busy_m && !w_busy_c) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq_sum    <= '0;
            r_peak      <= '0;
            r_peak_sq   <= '0;
            r_ovf       <= 1'b0;
            r_incl      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_incl <= i_cfg_include_max;
            end
            if (r_state == S_UPD) begin
                if (r_action) begin
                    r_count   <= '0;
                    r_sum     <= '0;
                    r_sq_sum  <= '0;
                    r_peak    <= '0;
                    r_peak_sq <= '0;
                    r_ovf     <= 1'b0;
                end else if (r_count == COUNT_MAX) begin
                    // drop the sample, keep the statistics
                    r_ovf <= 1'b1;
                end else begin
                    r_ovf    <= 1'b0;
                    r_count  <= r_count + 1'b1;
                    r_sum    <= r_sum + {{(SUM_BITS - SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}},
                                         r_sample};
                    r_sq_sum <= r_sq_sum + {{(SQ_SUM_BITS - SQ_BITS){1'b0}}, r_sq};
                    if (w_new_peak) begin
                        r_peak    <= r_sample;
                        r_peak_sq <= r_sq;
                    end
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_action <= i_action;
            r_sample <= i_sample;
            r_sq     <= w_in_sq;
        end
        if (r_state == S_PREP) begin
            r_neg         <= w_neg;
            r_mean_zero   <= w_mean_zero;
            r_contra_zero <= w_contra_zero;
        end
        if (w_load_out) begin
            r_out_mean  <= w_mean;
            r_out_ch    <= w_ch;
            r_out_count <= r_count;
            r_out_peak  <= r_peak;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_out_valid         = r_out_valid;
    assign o_mean_q8           = r_out_mean;
    assign o_contraharmonic_q8 = r_out_ch;

    // the next word may update the statistics while this result still waits,
    // so hold a copy of them alongside the means
    assign o_count    = r_out_count;
    assign o_largest  = r_out_peak;
    assign o_overflow = r_out_ovf;

endmodule

FILE: sv/rmcs_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rmcs_pkg for the dividend and divisor widths.
module rmcs_div import rmcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_dividend,
    input  logic [DIV_DEN_W-1:0] i_divisor,
    output logic                 o_busy,
    output logic [DIV_NUM_W-1:0] o_quotient
);

    logic                  r_busy;
    logic [DIV_STEP_W-1:0] r_step;
    logic [DIV_DEN_W-1:0]  r_rem;
    logic [DIV_NUM_W-1:0]  r_quo;
    logic [DIV_DEN_W-1:0]  r_div;

    logic [DIV_DEN_W:0]    w_shift;
    logic [DIV_DEN_W+1:0]  w_diff;
    logic                  w_fits;

    // bring down the next dividend bit and try a subtract
    assign w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};
    assign w_fits  = ~w_diff[DIV_DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= DIV_STEP_W'(DIV_NUM_W - 1);
        end else if (r_busy) begin
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: sv/rmcs_checker.sv
// Port-level checks for running_mean_contraharmonic_stats, bound to the top level.
// Depends on rmcs_pkg for field widths.
module rmcs_checker import rmcs_pkg::*; (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [MEAN_BITS-1:0]   i_mean,
    input logic [CH_BITS-1:0]            i_contra,
    input logic [COUNT_BITS-1:0]         i_count,
    input logic signed [SAMPLE_BITS-1:0] i_largest,
    input logic                          i_overflow
);

    // a result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    // one word at a time: ready drops right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a word is in progress");

    // a dropped sample only happens at a saturated count
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_overflow |-> i_count == {COUNT_BITS{1'b1}})
        else $error("overflow reported below the count limit");

    // empty statistics report zeros
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_count == '0 |->
            i_mean == '0 && i_contra == '0 && i_largest == '0)
        else $error("nonzero result with no samples");

endmodule

bind running_mean_contraharmonic_stats rmcs_checker u_rmcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_mean      (o_mean_q8),
    .i_contra    (o_contraharmonic_q8),
    .i_count     (o_count),
    .i_largest   (o_largest),
    .i_overflow  (o_overflow)
);
